// File: rtl/htfd_pkg.sv
`default_nettype none
package htfd_pkg;

  localparam int DATA_W = 8;
  localparam int TEMP_W = 15;
  localparam int HUM_W  = 14;
  localparam int WORD_W = 16;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [12:0]       TEMP_SCALE  = 13'd4375;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;
  localparam int                TEMP_SHIFT  = 14;
  localparam logic [9:0]        HUM_SCALE   = 10'd625;
  localparam int                HUM_SHIFT   = 12;

  typedef logic [DATA_W-1:0]        byte_t;
  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [HUM_W-1:0]         hum_t;
  typedef logic [WORD_W-1:0]        word_t;

  // CRC-8, MSB first, one data byte folded into the running value.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input byte_t b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/htfd_if.sv
`default_nettype none
interface htfd_byte_if import htfd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface htfd_result_if import htfd_pkg::*; ();
  logic  valid;
  logic  ready;
  temp_t temperature_centi;
  hum_t  humidity_centi;
  logic  frame_ok;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output frame_ok, input ready);
  modport sink   (input valid, input temperature_centi, input humidity_centi,
                  input frame_ok, output ready);
endinterface
`default_nettype wire

// File: rtl/humidity_temp_frame_decoder_top.sv
`default_nettype none
// Decodes the six-byte measurement frame of a humidity and temperature sensor.
// in_chan carries one frame byte per transfer, in the order temperature MSB,
// temperature LSB, temperature CRC, humidity MSB, humidity LSB, humidity CRC,
// with frame_start marking a byte as the first byte of a frame. Each word is
// checked with CRC-8 (polynomial 0x31, initial value 0xFF).
// out_chan carries one result per completed frame: temperature and humidity
// in hundredths, and frame_ok. When a CRC fails, frame_ok is low and both
// values are zero.
// Throughput is one byte per cycle while no byte is held off. The result is valid
// in the cycle after the transfer of the sixth byte; the CRC step and both
// scaling multiplies sit between the frame state registers and the result register.
// A synchronous reset returns the byte position to zero, the running CRC to
// 0xFF and drops any pending result. While a result waits on out_chan, bytes
// are still taken; only a byte that could finish the next frame is held off
// until the waiting result is transferred.
module humidity_temp_frame_decoder_top import htfd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  htfd_byte_if.sink     in_chan,
  htfd_result_if.source out_chan
);

  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  logic [2:0] pos_r, pos_nxt, pos_eff;
  logic [7:0] crc_r, crc_nxt, crc_eff;
  word_t      t_word_r, t_word_nxt;
  word_t      h_word_r, h_word_nxt;
  logic       t_good_r, t_good_nxt;

  logic       out_valid_r;
  temp_t      temp_r;
  hum_t       hum_r;
  logic       ok_r;

  logic       in_xfer;
  logic       frame_done;
  logic       frame_good;
  logic [28:0] t_prod;
  logic [25:0] h_prod;
  temp_t      temp_val;
  hum_t       hum_val;

  // Hold off only when a result is stuck and this byte might end a frame.
  assign in_chan.ready = !(out_valid_r && !out_chan.ready) || (pos_r != POS_H_CRC);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_comb begin
    if (in_chan.frame_start || (pos_r > POS_H_CRC)) begin
      pos_eff = POS_T_MSB;
      crc_eff = CRC_INIT;
    end else begin
      pos_eff = pos_r;
      crc_eff = crc_r;
    end
  end

  always_comb begin
    pos_nxt    = pos_eff + 3'd1;
    crc_nxt    = crc_eff;
    t_word_nxt = t_word_r;
    h_word_nxt = h_word_r;
    t_good_nxt = t_good_r;
    frame_done = 1'b0;
    frame_good = 1'b0;
    unique case (pos_eff)
      POS_T_MSB: begin
        crc_nxt    = crc8_byte(crc_eff, in_chan.data_byte);
        t_word_nxt = {in_chan.data_byte, t_word_r[7:0]};
      end
      POS_T_LSB: begin
        crc_nxt    = crc8_byte(crc_eff, in_chan.data_byte);
        t_word_nxt = {t_word_r[15:8], in_chan.data_byte};
      end
      POS_T_CRC: begin
        t_good_nxt = (in_chan.data_byte == crc_eff);
        crc_nxt    = CRC_INIT;
      end
      POS_H_MSB: begin
        crc_nxt    = crc8_byte(crc_eff, in_chan.data_byte);
        h_word_nxt = {in_chan.data_byte, h_word_r[7:0]};
      end
      POS_H_LSB: begin
        crc_nxt    = crc8_byte(crc_eff, in_chan.data_byte);
        h_word_nxt = {h_word_r[15:8], in_chan.data_byte};
      end
      default: begin
        frame_done = 1'b1;
        frame_good = t_good_r && (in_chan.data_byte == crc_eff);
        crc_nxt    = CRC_INIT;
        pos_nxt    = POS_T_MSB;
      end
    endcase
  end

  assign t_prod   = 29'(t_word_r) * 29'(TEMP_SCALE);
  assign h_prod   = 26'(h_word_r) * 26'(HUM_SCALE);
  assign temp_val = temp_t'(t_prod[TEMP_SHIFT +: TEMP_W] - TEMP_OFFSET);
  assign hum_val  = h_prod[HUM_SHIFT +: HUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_T_MSB;
      crc_r       <= CRC_INIT;
      t_word_r    <= '0;
      h_word_r    <= '0;
      t_good_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        pos_r    <= pos_nxt;
        crc_r    <= crc_nxt;
        t_word_r <= t_word_nxt;
        h_word_r <= h_word_nxt;
        t_good_r <= t_good_nxt;
      end
      if (in_xfer && frame_done) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && frame_done) begin
      ok_r   <= frame_good;
      temp_r <= frame_good ? temp_val : '0;
      hum_r  <= frame_good ? hum_val : '0;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.temperature_centi = temp_r;
  assign out_chan.humidity_centi    = hum_r;
  assign out_chan.frame_ok          = ok_r;

endmodule
`default_nettype wire

// File: rtl/htfd_checker.sv
`default_nettype none
module htfd_checker import htfd_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire temp_t out_temp,
  input wire hum_t  out_hum,
  input wire logic  out_ok
);

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped before its transfer");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_temp) && $stable(out_hum) && $stable(out_ok))
    else $error("stalled result changed");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> (out_temp == '0) && (out_hum == '0))
    else $error("failed frame carries nonzero values");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hum <= 14'd9999) && (out_temp >= -15'sd4500)
                  && (out_temp <= 15'sd12999))
    else $error("result value out of range");

endmodule

bind humidity_temp_frame_decoder_top htfd_checker u_htfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_temp  (out_chan.temperature_centi),
  .out_hum   (out_chan.humidity_centi),
  .out_ok    (out_chan.frame_ok)
);
`default_nettype wire

// File: verif/testbench.sv
`default_nettype none

typedef struct {
  htfd_pkg::temp_t temp;
  htfd_pkg::hum_t  hum;
  logic            ok;
} reading_t;

// Bitwise CRC-8 update: each data bit is compared with the CRC top bit.
function automatic logic [7:0] fold_crc_byte(input logic [7:0] crc, input logic [7:0] b);
  logic [7:0] c;
  logic       fb;
  c = crc;
  for (int i = 7; i >= 0; i--) begin
    fb = c[7] ^ b[i];
    c = {c[6:0], 1'b0} ^ (fb ? htfd_pkg::CRC_POLY : 8'h00);
  end
  return c;
endfunction

class frame_checker;
  logic [2:0]       position;
  logic [7:0]       crc;
  htfd_pkg::word_t  temp_word;
  htfd_pkg::word_t  hum_word;
  logic             temp_good;
  reading_t         pending_readings[$];
  int               errors;

  function new();
    position  = 3'd0;
    crc       = htfd_pkg::CRC_INIT;
    temp_word = '0;
    hum_word  = '0;
    temp_good = 1'b0;
    errors    = 0;
  endfunction

  task report(string what);
    if (errors < 40) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    errors++;
  endtask

  function int pending();
    return pending_readings.size();
  endfunction

  // Advances the frame state by one transferred byte and queues a reading
  // when the byte closes a frame.
  function void take_byte(htfd_pkg::byte_t b, logic start);
    logic [2:0]  pos;
    logic [31:0] t32;
    logic [31:0] h32;
    reading_t    r;
    pos = position;
    if (start || pos > 3'd5) begin
      pos = 3'd0;
      crc = htfd_pkg::CRC_INIT;
    end
    case (pos)
      3'd0: begin
        crc = fold_crc_byte(crc, b);
        temp_word[15:8] = b;
      end
      3'd1: begin
        crc = fold_crc_byte(crc, b);
        temp_word[7:0] = b;
      end
      3'd2: begin
        temp_good = (b == crc);
        crc = htfd_pkg::CRC_INIT;
      end
      3'd3: begin
        crc = fold_crc_byte(crc, b);
        hum_word[15:8] = b;
      end
      3'd4: begin
        crc = fold_crc_byte(crc, b);
        hum_word[7:0] = b;
      end
      default: begin
        r.ok = temp_good && (b == crc);
        t32 = '0;
        h32 = '0;
        if (r.ok) begin
          t32 = ((32'(htfd_pkg::TEMP_SCALE) * 32'(temp_word)) >> htfd_pkg::TEMP_SHIFT)
                - 32'(htfd_pkg::TEMP_OFFSET);
          h32 = (32'(htfd_pkg::HUM_SCALE) * 32'(hum_word)) >> htfd_pkg::HUM_SHIFT;
        end
        r.temp = t32[14:0];
        r.hum  = h32[13:0];
        pending_readings.push_back(r);
        crc = htfd_pkg::CRC_INIT;
        position = 3'd0;
        return;
      end
    endcase
    position = pos + 3'd1;
  endfunction

  task check_reading(htfd_pkg::temp_t temp, htfd_pkg::hum_t hum, logic ok);
    reading_t want;
    if (pending_readings.size() == 0) begin
      report($sformatf("reading with none expected: t=%0d h=%0d ok=%0b", temp, hum, ok));
      return;
    end
    want = pending_readings.pop_front();
    if (ok !== want.ok) begin
      report($sformatf("frame_ok %0b, expected %0b", ok, want.ok));
    end
    if (temp !== want.temp) begin
      report($sformatf("temperature_centi %0d, expected %0d", temp, want.temp));
    end
    if (hum !== want.hum) begin
      report($sformatf("humidity_centi %0d, expected %0d", hum, want.hum));
    end
  endtask
endclass

module testbench;
  import htfd_pkg::*;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   bytes_sent;
  frame_checker sb;

  htfd_byte_if   in_if ();
  htfd_result_if out_if ();

  humidity_temp_frame_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Both monitors sample the values from before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.take_byte(in_if.data_byte, in_if.frame_start);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_reading(out_if.temperature_centi, out_if.humidity_centi, out_if.frame_ok);
      end
    end
  end

  function automatic logic [7:0] word_crc(word_t w);
    return fold_crc_byte(fold_crc_byte(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Leaves valid high between back-to-back transfers; returns at the edge of
  // the transfer.
  task automatic send_byte(byte_t b, logic start);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.frame_start <= start;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(word_t tw, word_t hw, bit bad_t, bit bad_h, bit start,
                            int n_bytes);
    byte_t fb[6];
    fb[0] = tw[15:8];
    fb[1] = tw[7:0];
    fb[2] = word_crc(tw) ^ (bad_t ? byte_t'($urandom_range(1, 255)) : 8'h00);
    fb[3] = hw[15:8];
    fb[4] = hw[7:0];
    fb[5] = word_crc(hw) ^ (bad_h ? byte_t'($urandom_range(1, 255)) : 8'h00);
    for (int i = 0; i < n_bytes; i++) begin
      send_byte(fb[i], (i == 0) && start);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic word_t pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    return word_t'($urandom_range(0, 65535));
  endfunction

  task automatic random_traffic(int target);
    int r;
    int n;
    while (bytes_sent < target) begin
      r = $urandom_range(99);
      if (r < 80) begin
        send_frame(pick_word(), pick_word(), $urandom_range(99) < 12,
                   $urandom_range(99) < 12, $urandom_range(99) < 85, 6);
      end else if (r < 90) begin
        // Truncated frame; the next frame start drops it.
        send_frame(pick_word(), pick_word(), 1'b0, 1'b0, 1'b1, $urandom_range(1, 5));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(byte_t'($urandom_range(0, 255)), $urandom_range(99) < 30);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.frame_start = 1'b0;
    out_if.ready = 1'b0;
    bytes_sent = 0;
    send_idle_pct = 8;
    recv_idle_pct = 62;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Lowest and highest raw words, a frame that relies on the position
    // wrapping, both kinds of CRC failure and a resync in the middle of a frame.
    send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 6);
    send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 6);
    send_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1, 6);
    send_frame(16'h1234, 16'hABCD, 1'b0, 1'b0, 1'b1, 2);
    send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b1, 6);
    drain();

    random_traffic(bytes_sent + 430);
    drain();
    send_idle_pct = 62;
    recv_idle_pct = 8;
    random_traffic(bytes_sent + 430);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(bytes_sent + 430);

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire
